@@ hdl/aafc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package aafc_pkg;

    localparam int NUM_PLANES = 6;
    localparam int IDX_W      = 3;
    localparam int COORD_W    = 16;
    localparam int NRM_W      = 16;
    localparam int DIST_W     = 32;
    localparam int PROD_W     = NRM_W + COORD_W;
    localparam int DIST_SH    = 6;
    localparam int D64_W      = DIST_W + DIST_SH;
    localparam int ACC_W      = D64_W + 2;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_TEST  = 1'b1
    } t_aafc_op;

    typedef struct packed {
        t_aafc_op                   operation;
        logic [IDX_W-1:0]           plane_index;
        logic signed [NRM_W-1:0]    normal_x;
        logic signed [NRM_W-1:0]    normal_y;
        logic signed [NRM_W-1:0]    normal_z;
        logic signed [DIST_W-1:0]   plane_dist;
        logic signed [COORD_W-1:0]  min_x;
        logic signed [COORD_W-1:0]  min_y;
        logic signed [COORD_W-1:0]  min_z;
        logic signed [COORD_W-1:0]  max_x;
        logic signed [COORD_W-1:0]  max_y;
        logic signed [COORD_W-1:0]  max_z;
    } t_aafc_in;

    typedef struct packed {
        logic visible;
    } t_aafc_out;

    // z in the top bits, x in the bottom
    typedef struct packed {
        logic signed [NRM_W-1:0] z;
        logic signed [NRM_W-1:0] y;
        logic signed [NRM_W-1:0] x;
    } t_aafc_nrm;

    // per-stage advance strobes of the test pipeline
    typedef struct packed {
        logic a;
        logic b;
        logic c;
    } t_aafc_adv;

    // Coordinate that maximises n*v over {lo, hi}; min and max may be swapped.
    function automatic logic signed [COORD_W-1:0] sel_coord(
        input logic signed [NRM_W-1:0]   n,
        input logic signed [COORD_W-1:0] lo,
        input logic signed [COORD_W-1:0] hi
    );
        logic hi_gt;
        hi_gt = hi > lo;
        if (n[NRM_W-1]) begin
            return hi_gt ? lo : hi;
        end
        return hi_gt ? hi : lo;
    endfunction

endpackage

`default_nettype wire

@@ hdl/aafc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface aafc_in_if;
    logic               valid;
    logic               ready;
    aafc_pkg::t_aafc_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface aafc_out_if;
    logic                valid;
    logic                ready;
    aafc_pkg::t_aafc_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/aabb_frustum_cull.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Box tests pass through stages A, B and C and the output register before the result is valid.
// Throughput: one word per cycle while the output is not stalled; plane writes give no result.
// A plane write is seen by every test accepted after it.
// Synchronous active-low reset empties the pipeline and zeroes all planes,
// so every box tested before a plane write is visible.

module aabb_frustum_cull (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    aafc_in_if.sink    i_in,
    aafc_out_if.source o_out
);
    import aafc_pkg::*;

    t_aafc_nrm                r_nrm [NUM_PLANES];
    logic signed [DIST_W-1:0] r_dst [NUM_PLANES];
    logic                     r_va, r_vb, r_vc, r_vd;
    logic                     r_vis;
    t_aafc_adv                adv;
    logic                     en_d;
    logic                     in_acc;
    logic [NUM_PLANES-1:0]    behind;

    // each stage moves when empty or when the one after it moves
    assign en_d   = !r_vd || o_out.ready;
    assign adv.c  = !r_vc || en_d;
    assign adv.b  = !r_vb || adv.c;
    assign adv.a  = !r_va || adv.b;

    assign i_in.ready = adv.a;
    assign in_acc     = i_in.valid && adv.a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            for (int p = 0; p < NUM_PLANES; p++) begin
                r_nrm[p] <= '0;
                r_dst[p] <= '0;
            end
        end else begin
            if (adv.a) begin
                r_va <= in_acc && (i_in.data.operation == OP_TEST);
            end
            if (adv.b) begin
                r_vb <= r_va;
            end
            if (adv.c) begin
                r_vc <= r_vb;
            end
            if (en_d) begin
                r_vd <= r_vc;
            end
            // indices past the last plane match nothing
            for (int p = 0; p < NUM_PLANES; p++) begin
                if (in_acc && (i_in.data.operation == OP_WRITE) &&
                    (i_in.data.plane_index == IDX_W'(p))) begin
                    r_nrm[p] <= '{z: i_in.data.normal_z,
                                  y: i_in.data.normal_y,
                                  x: i_in.data.normal_x};
                    r_dst[p] <= i_in.data.plane_dist;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_d && r_vc) begin
            r_vis <= ~|behind;
        end
    end

    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_plane
        aafc_plane u_plane (
            .i_clk    (i_clk),
            .i_adv    (adv),
            .i_nrm    (r_nrm[g]),
            .i_dist   (r_dst[g]),
            .i_box    (i_in.data),
            .o_behind (behind[g])
        );
    end

    assign o_out.valid        = r_vd;
    assign o_out.data.visible = r_vis;

endmodule

`default_nettype wire

@@ hdl/aafc_plane.sv @@
`timescale 1ns / 1ps
`default_nettype none

module aafc_plane (
    input  wire logic                              i_clk,
    input  wire aafc_pkg::t_aafc_adv               i_adv,
    input  wire aafc_pkg::t_aafc_nrm               i_nrm,
    input  wire logic signed [aafc_pkg::DIST_W-1:0] i_dist,
    input  wire aafc_pkg::t_aafc_in                i_box,
    output logic                                   o_behind
);
    import aafc_pkg::*;

    // stage A: normal snapshot and farthest corner along the normal
    t_aafc_nrm                 r_nrm;
    logic signed [COORD_W-1:0] r_px, r_py, r_pz;
    logic signed [DIST_W-1:0]  r_d;
    // stage B: products
    logic signed [PROD_W-1:0]  r_prx, r_pry, r_prz;
    logic signed [D64_W-1:0]   r_d64;
    // stage C: verdict
    logic                      r_behind;
    logic signed [ACC_W-1:0]   n_diff;

    always_ff @(posedge i_clk) begin
        if (i_adv.a) begin
            r_nrm <= i_nrm;
            r_d   <= i_dist;
            r_px  <= sel_coord(i_nrm.x, i_box.min_x, i_box.max_x);
            r_py  <= sel_coord(i_nrm.y, i_box.min_y, i_box.max_y);
            r_pz  <= sel_coord(i_nrm.z, i_box.min_z, i_box.max_z);
        end
        if (i_adv.b) begin
            r_prx <= r_nrm.x * r_px;
            r_pry <= r_nrm.y * r_py;
            r_prz <= r_nrm.z * r_pz;
            r_d64 <= {r_d, {DIST_SH{1'b0}}};
        end
        if (i_adv.c) begin
            r_behind <= n_diff[ACC_W-1];
        end
    end

    // worst corner behind means all eight are
    assign n_diff = ACC_W'(r_prx) + ACC_W'(r_pry) + ACC_W'(r_prz) - ACC_W'(r_d64);

    assign o_behind = r_behind;

endmodule

`default_nettype wire

@@ hdl/aafc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module aafc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_in_op,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_visible
);
    import aafc_pkg::*;

    logic test_acc;
    assign test_acc = i_in_valid && i_in_ready && (i_in_op == OP_TEST);

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_visible))
        else $error("stalled result word changed or dropped");

    // an empty output stage must never hold off the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with output stage empty");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        test_acc ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready |=> i_out_valid)
        else $error("box result late");

endmodule

bind aabb_frustum_cull aafc_checker u_aafc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_op       (i_in.data.operation),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_visible (o_out.data.visible)
);

`default_nettype wire
